>>> rtl/i2cmws_pkg.sv
`default_nettype none

package i2cmws_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_START  = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_SEND  = 3'd2,
        ACT_RACK  = 3'd3,
        ACT_RNACK = 3'd4,
        ACT_STOP  = 3'd5,
        ACT_RESET = 3'd6
    } action_t;

    // Engine status codes, upper five bits of the raw status byte.
    localparam logic [4:0] ST_START      = 5'h01;
    localparam logic [4:0] ST_RESTART    = 5'h02;
    localparam logic [4:0] ST_SLAW_ACK   = 5'h03;
    localparam logic [4:0] ST_SLAW_NACK  = 5'h04;
    localparam logic [4:0] ST_DATA_ACK   = 5'h05;
    localparam logic [4:0] ST_DATA_NACK  = 5'h06;
    localparam logic [4:0] ST_SLAR_ACK   = 5'h08;
    localparam logic [4:0] ST_SLAR_NACK  = 5'h09;
    localparam logic [4:0] ST_RXDATA_ACK = 5'h0A;
    localparam logic [4:0] ST_RXDATA_NAK = 5'h0B;

    typedef struct packed {
        logic error;
        logic rdy;
        logic slanack;
        logic read;
        logic write;
        logic busy;
    } flags_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] tx;
        logic       tx_from_mem;
        logic       rv_from_mem;
        flags_t     flags;
        logic [5:0] wcount;
        logic [5:0] rcount;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/i2c_master_write_read_sequencer.sv
`default_nettype none

// Runs one I2C master transaction (optional write phase, optional repeated-start
// read phase) above a byte-level two-wire engine. Every input word is a command:
// load a frame buffer byte, start a transaction, report an engine status, or read
// a frame buffer byte. Each word yields exactly one result word with the next bus
// action, the byte to send, the transaction flags and the recorded counts. One
// word is accepted per clock cycle unless the output is stalled; its result is
// held in stage one beside the registered RAM read, then in the output register.
// Transaction state is updated in the accept cycle, so consecutive words never
// wait on each other. A stalled output holds one result and one more in flight.
module i2c_master_write_read_sequencer #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] cmd,
    input  wire logic [4:0] buf_index,
    input  wire logic [7:0] buf_value,
    input  wire logic [6:0] target_address,
    input  wire logic [5:0] write_len,
    input  wire logic [5:0] read_len,
    input  wire logic       want_write,
    input  wire logic       want_read,
    input  wire logic       scl_high,
    input  wire logic [7:0] bus_status,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [2:0] bus_action,
    output logic      [7:0] tx_byte,
    output logic            busy_flag,
    output logic            ready_flag,
    output logic            addr_nack_flag,
    output logic            error_flag,
    output logic            write_pending,
    output logic            read_pending,
    output logic      [7:0] read_value,
    output logic      [5:0] bytes_written,
    output logic      [5:0] bytes_read
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int PW = $clog2(BUFFER_DEPTH + 1);
    localparam int CW = (PW > 6) ? PW : 6;
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

    logic [CW-1:0] bp_reg, bp_next;
    logic [6:0]    addr_reg, addr_next;
    logic [CW-1:0] wc_reg, wc_next;
    logic [CW-1:0] rc_reg, rc_next;
    i2cmws_pkg::flags_t flags_reg, flags_next;

    logic s1_valid_reg;
    i2cmws_pkg::res_t s1_reg, s1_next;

    logic               out_valid_reg;
    i2cmws_pkg::action_t out_action_reg;
    logic [7:0]         out_tx_reg;
    i2cmws_pkg::flags_t out_flags_reg;
    logic [7:0]         out_rv_reg;
    logic [5:0]         out_wc_reg;
    logic [5:0]         out_rc_reg;

    logic          accept;
    logic          s1_adv;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    logic [CW-1:0] idx_ext;
    logic          idx_ok;
    logic          bp_ok;
    logic [CW-1:0] bp_inc;
    logic [CW-1:0] bp_rx;
    logic          rx_ack;
    logic [CW-1:0] wlen_c;
    logic [CW-1:0] rlen_c;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign idx_ext = CW'(buf_index);
    assign idx_ok  = idx_ext < DEPTH_C;
    assign bp_ok   = bp_reg < DEPTH_C;
    assign bp_inc  = bp_reg + CW'(1);
    assign bp_rx   = bp_ok ? bp_inc : bp_reg;
    assign rx_ack  = ({1'b0, bp_rx} + (CW + 1)'(1)) < {1'b0, rc_reg};
    assign wlen_c  = (CW'(write_len) > DEPTH_C) ? DEPTH_C : CW'(write_len);
    assign rlen_c  = (CW'(read_len) > DEPTH_C) ? DEPTH_C : CW'(read_len);

    always_comb
    begin
        bp_next    = bp_reg;
        addr_next  = addr_reg;
        wc_next    = wc_reg;
        rc_next    = rc_reg;
        flags_next = flags_reg;
        ram_we     = 1'b0;
        ram_addr   = idx_ext[AW-1:0];
        ram_wdata  = buf_value;
        s1_next.action      = i2cmws_pkg::ACT_NONE;
        s1_next.tx          = 8'h00;
        s1_next.tx_from_mem = 1'b0;
        s1_next.rv_from_mem = 1'b0;

        case (cmd)
            i2cmws_pkg::CMD_LOAD:
            begin
                ram_we = idx_ok;
            end
            i2cmws_pkg::CMD_START:
            begin
                addr_next        = target_address;
                wc_next          = wlen_c;
                rc_next          = rlen_c;
                flags_next       = '0;
                flags_next.write = want_write;
                flags_next.read  = want_read;
                if (scl_high)
                begin
                    flags_next.busy = 1'b1;
                    s1_next.action  = i2cmws_pkg::ACT_START;
                end
            end
            i2cmws_pkg::CMD_STATUS:
            begin
                case (bus_status[7:3])
                    i2cmws_pkg::ST_START, i2cmws_pkg::ST_RESTART:
                    begin
                        bp_next        = '0;
                        s1_next.tx     = {addr_reg, ~flags_reg.write};
                        s1_next.action = i2cmws_pkg::ACT_SEND;
                    end
                    i2cmws_pkg::ST_SLAW_NACK, i2cmws_pkg::ST_SLAR_NACK:
                    begin
                        rc_next            = '0;
                        flags_next.slanack = 1'b1;
                        s1_next.action     = i2cmws_pkg::ACT_STOP;
                    end
                    i2cmws_pkg::ST_SLAW_ACK, i2cmws_pkg::ST_DATA_ACK,
                    i2cmws_pkg::ST_DATA_NACK:
                    begin
                        ram_addr = bp_reg[AW-1:0];
                        if ((bus_status[7:3] != i2cmws_pkg::ST_DATA_NACK)
                            && (bp_reg < wc_reg) && bp_ok)
                        begin
                            bp_next             = bp_inc;
                            s1_next.tx_from_mem = 1'b1;
                            s1_next.action      = i2cmws_pkg::ACT_SEND;
                        end
                        else
                        begin
                            wc_next          = bp_reg;
                            flags_next.write = 1'b0;
                            if (!flags_reg.read)
                            begin
                                rc_next         = '0;
                                flags_next      = '0;
                                flags_next.rdy  = 1'b1;
                                s1_next.action  = i2cmws_pkg::ACT_STOP;
                            end
                            else
                            begin
                                s1_next.action = i2cmws_pkg::ACT_START;
                            end
                        end
                    end
                    i2cmws_pkg::ST_RXDATA_ACK:
                    begin
                        ram_addr       = bp_reg[AW-1:0];
                        ram_wdata      = rx_byte;
                        ram_we         = bp_ok;
                        bp_next        = bp_rx;
                        s1_next.action = rx_ack ? i2cmws_pkg::ACT_RACK
                                                : i2cmws_pkg::ACT_RNACK;
                    end
                    i2cmws_pkg::ST_SLAR_ACK:
                    begin
                        s1_next.action = (({1'b0, bp_reg} + (CW + 1)'(1))
                                          < {1'b0, rc_reg})
                                         ? i2cmws_pkg::ACT_RACK
                                         : i2cmws_pkg::ACT_RNACK;
                    end
                    i2cmws_pkg::ST_RXDATA_NAK:
                    begin
                        ram_addr       = bp_reg[AW-1:0];
                        ram_wdata      = rx_byte;
                        ram_we         = bp_ok;
                        bp_next        = bp_rx;
                        rc_next        = bp_rx;
                        flags_next     = '0;
                        flags_next.rdy = 1'b1;
                        s1_next.action = i2cmws_pkg::ACT_STOP;
                    end
                    default:
                    begin
                        wc_next          = bp_reg;
                        rc_next          = CW'(1);
                        ram_addr         = '0;
                        ram_wdata        = bus_status;
                        ram_we           = 1'b1;
                        flags_next.error = 1'b1;
                        s1_next.action   = i2cmws_pkg::ACT_RESET;
                    end
                endcase
            end
            default:
            begin
                s1_next.rv_from_mem = idx_ok;
            end
        endcase

        s1_next.flags  = flags_next;
        s1_next.wcount = wc_next[5:0];
        s1_next.rcount = rc_next[5:0];
    end

    i2cmws_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_frame_ram (
        .clk  (clk),
        .en   (accept),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg        <= '0;
            addr_reg      <= '0;
            wc_reg        <= '0;
            rc_reg        <= '0;
            flags_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                bp_reg    <= bp_next;
                addr_reg  <= addr_next;
                wc_reg    <= wc_next;
                rc_reg    <= rc_next;
                flags_reg <= flags_next;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            out_action_reg <= s1_reg.action;
            out_tx_reg     <= s1_reg.tx_from_mem ? ram_rdata : s1_reg.tx;
            out_rv_reg     <= s1_reg.rv_from_mem ? ram_rdata : 8'h00;
            out_flags_reg  <= s1_reg.flags;
            out_wc_reg     <= s1_reg.wcount;
            out_rc_reg     <= s1_reg.rcount;
        end
    end

    assign out_valid      = out_valid_reg;
    assign bus_action     = out_action_reg;
    assign tx_byte        = out_tx_reg;
    assign busy_flag      = out_flags_reg.busy;
    assign ready_flag     = out_flags_reg.rdy;
    assign addr_nack_flag = out_flags_reg.slanack;
    assign error_flag     = out_flags_reg.error;
    assign write_pending  = out_flags_reg.write;
    assign read_pending   = out_flags_reg.read;
    assign read_value     = out_rv_reg;
    assign bytes_written  = out_wc_reg;
    assign bytes_read     = out_rc_reg;

endmodule

`default_nettype wire

>>> rtl/i2cmws_ram.sv
`default_nettype none

module i2cmws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

>>> dv/i2c_master_write_read_sequencer_test.sv
`default_nettype none

module i2c_master_write_read_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam int RANDOM_WORDS = 340;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum {CLEAN, BROKEN, OVERRUN} txn_mode_t;

    typedef struct packed {
        i2cmws_pkg::cmd_t op;
        logic [4:0]       idx;
        logic [7:0]       val;
        logic [6:0]       addr;
        logic [5:0]       wlen;
        logic [5:0]       rlen;
        logic             ww;
        logic             wr;
        logic             scl;
        logic [7:0]       status;
        logic [7:0]       rx;
    } word_t;

    typedef struct packed {
        i2cmws_pkg::action_t action;
        logic [7:0]          tx;
        logic                busy;
        logic                rdy;
        logic                nack;
        logic                err;
        logic                wpend;
        logic                rpend;
        logic [7:0]          rv;
        logic [5:0]          wc;
        logic [5:0]          rc;
    } result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] cmd = '0;
    logic [4:0] buf_index = '0;
    logic [7:0] buf_value = '0;
    logic [6:0] target_address = '0;
    logic [5:0] write_len = '0;
    logic [5:0] read_len = '0;
    logic       want_write = 1'b0;
    logic       want_read = 1'b0;
    logic       scl_high = 1'b0;
    logic [7:0] bus_status = '0;
    logic [7:0] rx_byte = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic       busy_flag;
    logic       ready_flag;
    logic       addr_nack_flag;
    logic       error_flag;
    logic       write_pending;
    logic       read_pending;
    logic [7:0] read_value;
    logic [5:0] bytes_written;
    logic [5:0] bytes_read;

    i2c_master_write_read_sequencer #(
        .BUFFER_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .buf_index(buf_index),
        .buf_value(buf_value),
        .target_address(target_address),
        .write_len(write_len),
        .read_len(read_len),
        .want_write(want_write),
        .want_read(want_read),
        .scl_high(scl_high),
        .bus_status(bus_status),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .bus_action(bus_action),
        .tx_byte(tx_byte),
        .busy_flag(busy_flag),
        .ready_flag(ready_flag),
        .addr_nack_flag(addr_nack_flag),
        .error_flag(error_flag),
        .write_pending(write_pending),
        .read_pending(read_pending),
        .read_value(read_value),
        .bytes_written(bytes_written),
        .bytes_read(bytes_read)
    );

    // Mirror of the transaction state, kept in step with every accepted word.
    logic [7:0]          frame [DEPTH];
    logic [DEPTH-1:0]    loaded = '0;
    int                  pointer = 0;
    int                  write_total = 0;
    int                  read_total = 0;
    logic [6:0]          slave = '0;
    i2cmws_pkg::flags_t  flags = '0;

    result_t awaited[$];
    int      mismatches = 0;
    int      words_sent = 0;
    int      results_seen = 0;
    int      burst_left = 0;
    bit      steady = 1'b0;
    int      hold_request = 0;
    int      hold_left = 0;
    int      ready_pct = 100;
    int      pattern_left = 0;
    int      cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_len(logic [5:0] len);
        return (len > DEPTH) ? DEPTH : int'(len);
    endfunction

    function automatic void keep_received(logic [7:0] data);
        if (pointer < DEPTH)
        begin
            frame[pointer] = data;
            loaded[pointer] = 1'b1;
            pointer++;
        end
    endfunction

    function automatic result_t next_bus_result(word_t w);
        result_t    r;
        logic [4:0] code;
        r = '0;
        code = w.status[7:3];
        case (w.op)
            i2cmws_pkg::CMD_LOAD:
            begin
                frame[w.idx] = w.val;
                loaded[w.idx] = 1'b1;
            end
            i2cmws_pkg::CMD_START:
            begin
                slave = w.addr;
                write_total = clamp_len(w.wlen);
                read_total = clamp_len(w.rlen);
                flags = '0;
                flags.write = w.ww;
                flags.read = w.wr;
                if (w.scl)
                begin
                    flags.busy = 1'b1;
                    r.action = i2cmws_pkg::ACT_START;
                end
            end
            i2cmws_pkg::CMD_STATUS:
            begin
                if (code == i2cmws_pkg::ST_START || code == i2cmws_pkg::ST_RESTART)
                begin
                    pointer = 0;
                    r.tx = {slave, ~flags.write};
                    r.action = i2cmws_pkg::ACT_SEND;
                end
                else if (code == i2cmws_pkg::ST_SLAW_NACK
                         || code == i2cmws_pkg::ST_SLAR_NACK)
                begin
                    read_total = 0;
                    flags.slanack = 1'b1;
                    r.action = i2cmws_pkg::ACT_STOP;
                end
                else if ((code == i2cmws_pkg::ST_SLAW_ACK
                          || code == i2cmws_pkg::ST_DATA_ACK)
                         && pointer < write_total && pointer < DEPTH)
                begin
                    r.tx = frame[pointer];
                    pointer++;
                    r.action = i2cmws_pkg::ACT_SEND;
                end
                else if (code == i2cmws_pkg::ST_SLAW_ACK || code == i2cmws_pkg::ST_DATA_ACK
                         || code == i2cmws_pkg::ST_DATA_NACK)
                begin
                    write_total = pointer;
                    flags.write = 1'b0;
                    if (!flags.read)
                    begin
                        read_total = 0;
                        flags = '0;
                        flags.rdy = 1'b1;
                        r.action = i2cmws_pkg::ACT_STOP;
                    end
                    else
                        r.action = i2cmws_pkg::ACT_START;
                end
                else if (code == i2cmws_pkg::ST_RXDATA_ACK
                         || code == i2cmws_pkg::ST_SLAR_ACK)
                begin
                    if (code == i2cmws_pkg::ST_RXDATA_ACK)
                        keep_received(w.rx);
                    r.action = (pointer + 1 < read_total) ? i2cmws_pkg::ACT_RACK
                                                          : i2cmws_pkg::ACT_RNACK;
                end
                else if (code == i2cmws_pkg::ST_RXDATA_NAK)
                begin
                    keep_received(w.rx);
                    read_total = pointer;
                    flags = '0;
                    flags.rdy = 1'b1;
                    r.action = i2cmws_pkg::ACT_STOP;
                end
                else
                begin
                    write_total = pointer;
                    read_total = 1;
                    frame[0] = w.status;
                    loaded[0] = 1'b1;
                    flags.error = 1'b1;
                    r.action = i2cmws_pkg::ACT_RESET;
                end
            end
            default:
                r.rv = frame[w.idx];
        endcase
        r.busy = flags.busy;
        r.rdy = flags.rdy;
        r.nack = flags.slanack;
        r.err = flags.error;
        r.wpend = flags.write;
        r.rpend = flags.read;
        r.wc = 6'(write_total);
        r.rc = 6'(read_total);
        return r;
    endfunction

    // A buffer entry that was never loaded must not be fetched, either by a
    // read word or by a data byte sent from the frame.
    function automatic bit reads_unloaded(word_t w, output logic [4:0] entry);
        logic [4:0] code;
        code = w.status[7:3];
        entry = w.idx;
        if (w.op == i2cmws_pkg::CMD_READ)
            return !loaded[w.idx];
        if (w.op == i2cmws_pkg::CMD_STATUS
            && (code == i2cmws_pkg::ST_SLAW_ACK || code == i2cmws_pkg::ST_DATA_ACK)
            && pointer < write_total && pointer < DEPTH)
        begin
            entry = 5'(pointer);
            return !loaded[pointer];
        end
        return 1'b0;
    endfunction

    function automatic word_t random_word(i2cmws_pkg::cmd_t op);
        logic [63:0] bits;
        word_t       w;
        bits = {$urandom, $urandom};
        w = bits[$bits(word_t)-1:0];
        w.op = op;
        return w;
    endfunction

    function automatic word_t status_word(logic [4:0] code);
        word_t w;
        w = random_word(i2cmws_pkg::CMD_STATUS);
        w.status[7:3] = code;
        return w;
    endfunction

    function automatic word_t start_word(logic [6:0] addr, logic [5:0] wlen,
                                         logic [5:0] rlen, logic ww, logic wr,
                                         logic scl);
        word_t w;
        w = random_word(i2cmws_pkg::CMD_START);
        w.addr = addr;
        w.wlen = wlen;
        w.rlen = rlen;
        w.ww = ww;
        w.wr = wr;
        w.scl = scl;
        return w;
    endfunction

    function automatic logic [5:0] pick_len();
        if ($urandom_range(0, 5) == 0)
            return 6'($urandom_range(32, 63));
        return 6'($urandom_range(0, 6));
    endfunction

    function automatic string describe(result_t r);
        return $sformatf("act=%0d tx=%h flags=%b rv=%h wc=%0d rc=%0d", r.action, r.tx,
                         {r.busy, r.rdy, r.nack, r.err, r.wpend, r.rpend}, r.rv, r.wc,
                         r.rc);
    endfunction

    task automatic put_word(input word_t w, output result_t r);
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!steady)
            begin
                repeat ($urandom_range(0, 6))
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        cmd <= w.op;
        buf_index <= w.idx;
        buf_value <= w.val;
        target_address <= w.addr;
        write_len <= w.wlen;
        read_len <= w.rlen;
        want_write <= w.ww;
        want_read <= w.wr;
        scl_high <= w.scl;
        bus_status <= w.status;
        rx_byte <= w.rx;
        do
            @(posedge clk);
        while (!in_ready);
        r = next_bus_result(w);
        awaited.push_back(r);
        words_sent++;
    endtask

    task automatic send_word(input word_t w, output result_t r);
        word_t      fill;
        logic [4:0] entry;
        if (reads_unloaded(w, entry))
        begin
            fill = random_word(i2cmws_pkg::CMD_LOAD);
            fill.idx = entry;
            put_word(fill, r);
        end
        put_word(w, r);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_transaction(input txn_mode_t mode);
        word_t   w;
        word_t   data;
        result_t r;
        int      nload;
        int      steps;
        bit      addr_next;
        bit      first_start;
        bit      running;
        w = start_word(7'($urandom), pick_len(), pick_len(), 1'($urandom), 1'($urandom),
                       1'b1);
        if (mode == OVERRUN)
        begin
            w.wr = 1'b1;
            w.rlen = 6'($urandom_range(32, 63));
        end
        nload = clamp_len(w.wlen);
        for (int i = 0; i < nload; i++)
        begin
            if (!loaded[i] || $urandom_range(0, 1) == 1)
            begin
                data = random_word(i2cmws_pkg::CMD_LOAD);
                data.idx = 5'(i);
                send_word(data, r);
            end
        end
        w.scl = ($urandom_range(0, 7) != 0);
        send_word(w, r);
        if (!w.scl)
        begin
            w.scl = 1'b1;
            send_word(w, r);
        end
        addr_next = 1'b0;
        first_start = 1'b1;
        running = 1'b1;
        steps = 0;
        while (running && steps < 120)
        begin
            steps++;
            w = random_word(i2cmws_pkg::CMD_STATUS);
            case (r.action)
                i2cmws_pkg::ACT_START:
                begin
                    w.status[7:3] = first_start ? i2cmws_pkg::ST_START
                                                : i2cmws_pkg::ST_RESTART;
                    first_start = 1'b0;
                    addr_next = 1'b1;
                end
                i2cmws_pkg::ACT_SEND:
                begin
                    if (addr_next && r.tx[0])
                        w.status[7:3] = ($urandom_range(0, 11) == 0)
                                        ? i2cmws_pkg::ST_SLAR_NACK
                                        : i2cmws_pkg::ST_SLAR_ACK;
                    else if (addr_next)
                        w.status[7:3] = ($urandom_range(0, 11) == 0)
                                        ? i2cmws_pkg::ST_SLAW_NACK
                                        : i2cmws_pkg::ST_SLAW_ACK;
                    else
                        w.status[7:3] = ($urandom_range(0, 9) == 0)
                                        ? i2cmws_pkg::ST_DATA_NACK
                                        : i2cmws_pkg::ST_DATA_ACK;
                    addr_next = 1'b0;
                end
                i2cmws_pkg::ACT_RACK:
                    w.status[7:3] = (mode == BROKEN && $urandom_range(0, 15) == 0)
                                    ? i2cmws_pkg::ST_RXDATA_NAK
                                    : i2cmws_pkg::ST_RXDATA_ACK;
                i2cmws_pkg::ACT_RNACK:
                    w.status[7:3] = (mode != CLEAN && $urandom_range(0, 3) != 0)
                                    ? i2cmws_pkg::ST_RXDATA_ACK
                                    : i2cmws_pkg::ST_RXDATA_NAK;
                default:
                    running = 1'b0;
            endcase
            if (running)
            begin
                if (mode == BROKEN && $urandom_range(0, 9) == 0)
                    w = random_word(i2cmws_pkg::cmd_t'($urandom_range(0, 3)));
                send_word(w, r);
            end
        end
    endtask

    task automatic test_buffer_extremes();
        word_t   w;
        result_t r;
        w = random_word(i2cmws_pkg::CMD_LOAD);
        w.idx = 5'd0;
        w.val = 8'h00;
        send_word(w, r);
        w.idx = 5'd31;
        w.val = 8'hFF;
        send_word(w, r);
        w = random_word(i2cmws_pkg::CMD_READ);
        w.idx = 5'd31;
        send_word(w, r);
        w.idx = 5'd0;
        send_word(w, r);
    endtask

    task automatic test_busy_bus_start();
        result_t r;
        send_word(start_word(7'h7F, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0), r);
    endtask

    task automatic test_status_while_idle();
        result_t r;
        send_word(status_word(i2cmws_pkg::ST_START), r);
        send_word(status_word(i2cmws_pkg::ST_SLAW_ACK), r);
    endtask

    task automatic test_write_then_read();
        word_t   w;
        result_t r;
        send_word(start_word(7'h00, 6'd1, 6'd0, 1'b1, 1'b1, 1'b1), r);
        send_word(status_word(i2cmws_pkg::ST_START), r);
        send_word(status_word(i2cmws_pkg::ST_SLAW_ACK), r);
        send_word(status_word(i2cmws_pkg::ST_DATA_ACK), r);
        send_word(status_word(i2cmws_pkg::ST_RESTART), r);
        send_word(status_word(i2cmws_pkg::ST_SLAR_ACK), r);
        w = status_word(i2cmws_pkg::ST_RXDATA_NAK);
        w.rx = 8'hA5;
        send_word(w, r);
    endtask

    task automatic test_data_nack();
        result_t r;
        send_word(start_word(7'h2A, 6'd2, 6'd5, 1'b1, 1'b0, 1'b1), r);
        send_word(status_word(i2cmws_pkg::ST_START), r);
        send_word(status_word(i2cmws_pkg::ST_SLAW_ACK), r);
        send_word(status_word(i2cmws_pkg::ST_DATA_NACK), r);
    endtask

    task automatic test_address_nack();
        result_t r;
        send_word(start_word(7'h55, 6'd0, 6'd2, 1'b0, 1'b1, 1'b1), r);
        send_word(status_word(i2cmws_pkg::ST_START), r);
        send_word(status_word(i2cmws_pkg::ST_SLAR_NACK), r);
    endtask

    task automatic test_unknown_status();
        word_t   w;
        result_t r;
        w = random_word(i2cmws_pkg::CMD_STATUS);
        w.status = 8'h00;
        send_word(w, r);
        w.status = 8'hFF;
        send_word(w, r);
    endtask

    task automatic test_backpressure();
        result_t r;
        steady = 1'b1;
        hold_request = 200;
        for (int i = 0; i < 24; i++)
            send_word(random_word(i2cmws_pkg::cmd_t'($urandom_range(0, 3))), r);
        steady = 1'b0;
        drain_results();
    endtask

    task automatic test_random_transactions();
        result_t r;
        int      first;
        int      roll;
        first = words_sent;
        while (words_sent - first < RANDOM_WORDS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 9);
            if (roll == 0)
                run_transaction(OVERRUN);
            else if (roll < 4)
                run_transaction(BROKEN);
            else
                run_transaction(CLEAN);
            if ($urandom_range(0, 2) == 0)
                send_word(random_word(i2cmws_pkg::cmd_t'($urandom_range(0, 3))), r);
        end
        steady = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (pattern_left <= 0)
            begin
                pattern_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
            end
            pattern_left--;
            out_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {bus_action, tx_byte, busy_flag, ready_flag, addr_nack_flag, error_flag,
                   write_pending, read_pending, read_value, bytes_written, bytes_read};
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with none expected: %s", results_seen,
                             describe(got));
            end
            else
            begin
                want = awaited.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d expected %s", results_seen, describe(want));
                        $display("result %0d got      %s", results_seen, describe(got));
                    end
                end
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_buffer_extremes();
        test_busy_bus_start();
        test_status_while_idle();
        test_write_then_read();
        test_data_nack();
        test_address_nack();
        test_unknown_status();
        drain_results();
        test_backpressure();
        test_random_transactions();
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && awaited.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
